/* rtl/rds_pkg.sv */
// Shared types and constants for the region detection suppressor.
// No dependencies; the top level refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rds_pkg;

   // Fixed field widths
   localparam int CLASS_W  = 8;
   localparam int SCORE_W  = 16;
   localparam int OUT_W    = 16;
   localparam int FRAC_W   = 17;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 17;

   // Shared multiplier: 17 bit by 32 bit
   localparam int MUL_A_W = 17;
   localparam int MUL_B_W = 32;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Input beat action codes
   typedef enum logic [1:0] {
      ACT_LOAD   = 2'd0,
      ACT_DETECT = 2'd1,
      ACT_EOF    = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   // Result beat kinds
   typedef enum logic [1:0] {
      KIND_KEPT   = 2'd0,
      KIND_SCALED = 2'd1,
      KIND_REPLAY = 2'd2,
      KIND_FULL   = 2'd3
   } kind_type;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_SUPPRESS_CLASS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BORDER_CLASS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_FACTOR   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERLAP_RATIO  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EMIT_REGIONS   = 3'd4;

   // Register reset values
   localparam logic [FRAC_W-1:0] SCALE_RESET   = 17'd32768;
   localparam logic [FRAC_W-1:0] OVERLAP_RESET = 17'd32768;

endpackage

`default_nettype wire

/* rtl/rds_region_table.sv */
// Region table storage: one write port, one registered read port.
// Uses no package items; sized by its parameters.
`timescale 1ns / 1ps
`default_nettype none

module rds_region_table #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5,
   parameter int DATA_W = 72
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read every cycle, data appears in the next cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/region_detection_suppressor.sv */
// Region detection suppressor top level: sequencer, shared multiplier, csr file.
// Depends on rds_pkg and rds_region_table.
//
// Usage:
//   req_* carries one beat per item: load region, test detection or end of frame.
//   rsp_* carries result beats; rsp_last marks the final beat of one item.
//   csr_* writes the five control registers, taken while the block is idle.
// Item handling:
//   load region: no result unless the table is full (then a full result beat).
//   test detection: a result leaves unless the detection is dropped; with an
//     empty table no region is read; otherwise each region takes a table read, an
//     overlap-area multiply and a ratio compare on the one shared multiplier.
//   end of frame: regions may be replayed, one result beat each.
// The block takes one item at a time; req_stall is high while an item is in
// work. A finished result sits in the output register, so the next item is
// accepted while it waits. A held rsp_stall freezes the sequencer only at the
// point where it has the next result ready.
// Reset empties the region table (count only) and restores register defaults;
// the table storage itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module region_detection_suppressor #(
   parameter int MAX_REGIONS = 32,
   parameter int COORD_BITS  = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [15:0] req_left,
   input  wire logic [15:0] req_top,
   input  wire logic [15:0] req_right,
   input  wire logic [15:0] req_bottom,
   input  wire logic [7:0]  req_class_id,
   input  wire logic [15:0] req_score,
   // response channel
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [1:0]  rsp_kind,
   output      logic [15:0] rsp_out_left,
   output      logic [15:0] rsp_out_top,
   output      logic [15:0] rsp_out_right,
   output      logic [15:0] rsp_out_bottom,
   output      logic [7:0]  rsp_out_class,
   output      logic [15:0] rsp_out_score,
   output      logic        rsp_last,
   // configuration channel
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [16:0] csr_data
);

   localparam int C       = COORD_BITS;
   localparam int IDX_W   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W   = $clog2(MAX_REGIONS + 1);
   localparam int ENTRY_W = 4 * C + rds_pkg::CLASS_W;
   localparam int PW      = rds_pkg::PROD_W;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_DA_DIM   = 9'b000000010,
      ST_DA_RATIO = 9'b000000100,
      ST_RD       = 9'b000001000,
      ST_OV       = 9'b000010000,
      ST_CMP      = 9'b000100000,
      ST_EMIT     = 9'b001000000,
      ST_RP_RD    = 9'b010000000,
      ST_RP_OUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // control registers
   logic [rds_pkg::CLASS_W-1:0] suppress_ff, border_ff;
   logic [rds_pkg::FRAC_W-1:0]  scale_ff, ratio_ff;
   logic                        emit_ff;

   // sequencer state
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             saw_ff, saw_in;
   logic             keep_ff, keep_in;
   logic             adjust_ff, adjust_in;
   logic             hit_ff, hit_in;
   rds_pkg::kind_type kind_ff, kind_in;

   // captured item and arithmetic registers
   logic [C-1:0] l_ff, t_ff, r_ff, b_ff;
   logic [C-1:0] l_in, t_in, r_in, b_in;
   logic [rds_pkg::CLASS_W-1:0] cls_ff, cls_in, rc_ff, rc_in;
   logic [rds_pkg::SCORE_W-1:0] score_ff, score_in;
   logic [PW-1:0] prod_ff, prod_in, rd_ff, rd_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  o_kind_ff, o_kind_in;
   logic [15:0] o_l_ff, o_t_ff, o_r_ff, o_b_ff, o_l_in, o_t_in, o_r_in, o_b_in;
   logic [7:0]  o_cls_ff, o_cls_in;
   logic [15:0] o_score_ff, o_score_in;
   logic        o_last_ff, o_last_in;

   // table interface
   logic               tbl_wr_en;
   logic [ENTRY_W-1:0] tbl_wr_data;
   logic [ENTRY_W-1:0] tbl_rd_data;

   // shared multiplier
   logic [rds_pkg::MUL_A_W-1:0] mul_a;
   logic [rds_pkg::MUL_B_W-1:0] mul_b;
   logic [PW-1:0]               mul_p;

   logic                        req_accept, out_free, out_load;
   logic [C-1:0]                in_l, in_t, in_r, in_b;
   logic [C-1:0]                rl, rt, rr, rbt, x0, x1, y0, y1;
   logic [rds_pkg::CLASS_W-1:0] rcls;
   logic                        counts, scan_done, all_neutral;
   logic [15:0]                 scaled_score;

   rds_region_table #(
      .DEPTH  (MAX_REGIONS),
      .ADDR_W (IDX_W),
      .DATA_W (ENTRY_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (tbl_wr_data),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (tbl_rd_data)
   );

   // Handshakes
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Mask coordinates to the configured width
   assign in_l = req_left[C-1:0];
   assign in_t = req_top[C-1:0];
   assign in_r = req_right[C-1:0];
   assign in_b = req_bottom[C-1:0];

   assign tbl_wr_en   = req_accept && (req_action == rds_pkg::ACT_LOAD) &&
                        (count_ff < CNT_W'(MAX_REGIONS));
   assign tbl_wr_data = {req_class_id, in_b, in_r, in_t, in_l};

   // Unpack the region read back and intersect it with the detection
   assign rl   = tbl_rd_data[C-1:0];
   assign rt   = tbl_rd_data[2*C-1:C];
   assign rr   = tbl_rd_data[3*C-1:2*C];
   assign rbt  = tbl_rd_data[4*C-1:3*C];
   assign rcls = tbl_rd_data[ENTRY_W-1:4*C];
   assign x0   = (l_ff > rl)  ? l_ff : rl;
   assign x1   = (r_ff < rr)  ? r_ff : rr;
   assign y0   = (t_ff > rt)  ? t_ff : rt;
   assign y1   = (b_ff < rbt) ? b_ff : rbt;

   // Overlap counts when area * 2^16 reaches ratio * detection area
   assign counts      = hit_ff && ({1'b0, prod_ff[31:0], 16'b0} >= rd_ff);
   assign scan_done   = ((idx_ff + CNT_W'(1)) == count_ff);
   assign all_neutral = (suppress_ff == '0) && (border_ff == '0);

   // Select multiplier operands per step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_DA_DIM: begin
            mul_a = rds_pkg::MUL_A_W'(r_ff - l_ff);
            mul_b = rds_pkg::MUL_B_W'(b_ff - t_ff);
         end
         ST_DA_RATIO: begin
            mul_a = ratio_ff;
            mul_b = prod_ff[rds_pkg::MUL_B_W-1:0];
         end
         ST_OV: begin
            mul_a = rds_pkg::MUL_A_W'(x1 - x0);
            mul_b = rds_pkg::MUL_B_W'(y1 - y0);
         end
         ST_EMIT: begin
            mul_a = scale_ff;
            mul_b = rds_pkg::MUL_B_W'(score_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = PW'(mul_a) * PW'(mul_b);

   // Truncate the scaled score, saturate above full scale
   assign scaled_score = (|mul_p[PW-1:32]) ? 16'hFFFF : mul_p[31:16];

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      saw_in     = saw_ff;
      keep_in    = keep_ff;
      adjust_in  = adjust_ff;
      hit_in     = hit_ff;
      kind_in    = kind_ff;
      l_in       = l_ff;
      t_in       = t_ff;
      r_in       = r_ff;
      b_in       = b_ff;
      cls_in     = cls_ff;
      score_in   = score_ff;
      rc_in      = rc_ff;
      prod_in    = prod_ff;
      rd_in      = rd_ff;
      out_load   = 1'b0;
      o_kind_in  = o_kind_ff;
      o_l_in     = o_l_ff;
      o_t_in     = o_t_ff;
      o_r_in     = o_r_ff;
      o_b_in     = o_b_ff;
      o_cls_in   = o_cls_ff;
      o_score_in = o_score_ff;
      o_last_in  = o_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               l_in     = in_l;
               t_in     = in_t;
               r_in     = in_r;
               b_in     = in_b;
               cls_in   = req_class_id;
               score_in = req_score;
               idx_in   = '0;
               unique case (req_action)
                  rds_pkg::ACT_LOAD: begin
                     if (count_ff < CNT_W'(MAX_REGIONS)) begin
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        kind_in  = rds_pkg::KIND_FULL;
                        state_in = ST_EMIT;
                     end
                  end
                  rds_pkg::ACT_DETECT: begin
                     saw_in    = 1'b1;
                     keep_in   = 1'b1;
                     adjust_in = 1'b0;
                     kind_in   = rds_pkg::KIND_KEPT;
                     state_in  = (count_ff == '0) ? ST_EMIT : ST_DA_DIM;
                  end
                  rds_pkg::ACT_EOF: begin
                     if ((emit_ff || !saw_ff) && (count_ff != '0)) begin
                        state_in = ST_RP_RD;
                     end else begin
                        count_in = '0;
                        saw_in   = 1'b0;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DA_DIM: begin
            prod_in  = mul_p;
            state_in = ST_DA_RATIO;
         end
         ST_DA_RATIO: begin
            rd_in    = mul_p;
            state_in = ST_RD;
         end
         ST_RD: begin
            state_in = ST_OV;
         end
         ST_OV: begin
            hit_in   = (x0 < x1) && (y0 < y1);
            prod_in  = mul_p;
            rc_in    = rcls;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (counts) begin
               if ((suppress_ff == rc_ff) || all_neutral) begin
                  keep_in = 1'b0;
               end else if ((border_ff != '0) && (border_ff == rc_ff)) begin
                  adjust_in = 1'b1;
               end
            end
            idx_in = idx_ff + CNT_W'(1);
            if (scan_done) begin
               if (!keep_in) begin
                  state_in = ST_IDLE;
               end else begin
                  kind_in  = adjust_in ? rds_pkg::KIND_SCALED : rds_pkg::KIND_KEPT;
                  state_in = ST_EMIT;
               end
            end else begin
               state_in = ST_RD;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load   = 1'b1;
               o_kind_in  = kind_ff;
               o_l_in     = 16'(l_ff);
               o_t_in     = 16'(t_ff);
               o_r_in     = 16'(r_ff);
               o_b_in     = 16'(b_ff);
               o_cls_in   = cls_ff;
               o_score_in = (kind_ff == rds_pkg::KIND_SCALED) ? scaled_score : score_ff;
               o_last_in  = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_RP_RD: begin
            state_in = ST_RP_OUT;
         end
         ST_RP_OUT: begin
            if (out_free) begin
               out_load   = 1'b1;
               o_kind_in  = rds_pkg::KIND_REPLAY;
               o_l_in     = 16'(rl);
               o_t_in     = 16'(rt);
               o_r_in     = 16'(rr);
               o_b_in     = 16'(rbt);
               o_cls_in   = rcls;
               o_score_in = '0;
               o_last_in  = scan_done;
               idx_in     = idx_ff + CNT_W'(1);
               if (scan_done) begin
                  count_in = '0;
                  saw_in   = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RP_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result while stalled, drop it once taken
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // Sequencer and output-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         saw_ff       <= 1'b0;
         keep_ff      <= 1'b1;
         adjust_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         kind_ff      <= rds_pkg::KIND_KEPT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         saw_ff       <= saw_in;
         keep_ff      <= keep_in;
         adjust_ff    <= adjust_in;
         hit_ff       <= hit_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      l_ff       <= l_in;
      t_ff       <= t_in;
      r_ff       <= r_in;
      b_ff       <= b_in;
      cls_ff     <= cls_in;
      score_ff   <= score_in;
      rc_ff      <= rc_in;
      prod_ff    <= prod_in;
      rd_ff      <= rd_in;
      o_kind_ff  <= o_kind_in;
      o_l_ff     <= o_l_in;
      o_t_ff     <= o_t_in;
      o_r_ff     <= o_r_in;
      o_b_ff     <= o_b_in;
      o_cls_ff   <= o_cls_in;
      o_score_ff <= o_score_in;
      o_last_ff  <= o_last_in;
   end

   // Register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         suppress_ff <= '0;
         border_ff   <= '0;
         scale_ff    <= rds_pkg::SCALE_RESET;
         ratio_ff    <= rds_pkg::OVERLAP_RESET;
         emit_ff     <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rds_pkg::CSR_SUPPRESS_CLASS: suppress_ff <= csr_data[7:0];
            rds_pkg::CSR_BORDER_CLASS:   border_ff   <= csr_data[7:0];
            rds_pkg::CSR_SCALE_FACTOR:   scale_ff    <= csr_data;
            rds_pkg::CSR_OVERLAP_RATIO:  ratio_ff    <= csr_data;
            rds_pkg::CSR_EMIT_REGIONS:   emit_ff     <= csr_data[0];
            default:                     emit_ff     <= emit_ff;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = o_kind_ff;
   assign rsp_out_left   = o_l_ff;
   assign rsp_out_top    = o_t_ff;
   assign rsp_out_right  = o_r_ff;
   assign rsp_out_bottom = o_b_ff;
   assign rsp_out_class  = o_cls_ff;
   assign rsp_out_score  = o_score_ff;
   assign rsp_last       = o_last_ff;

endmodule

`default_nettype wire
